FILE: design/vpw_pkg.sv
// ---------------------------------------------------------------------------
// vpw_pkg
// Shared types, constants and helpers for the vertex projection block.
// ---------------------------------------------------------------------------
package vpw_pkg;

   // number format
   localparam int FRAC_BITS  = 16;
   localparam int WORD_WIDTH = 32;
   localparam int PROD_WIDTH = 2 * WORD_WIDTH;
   localparam int ACC_WIDTH  = PROD_WIDTH - FRAC_BITS + 2;
   localparam int DIV_STAGES = WORD_WIDTH + FRAC_BITS;
   localparam int DIV_LAT    = DIV_STAGES + 2;
   localparam int VP_WIDTH   = 16;
   localparam int MUL_WIDTH  = WORD_WIDTH + VP_WIDTH + 1;

   typedef logic signed [WORD_WIDTH-1:0] word_type;
   typedef logic [3:0][WORD_WIDTH-1:0] vec4_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
   localparam word_type FIX_ONE  = word_type'(64'd1 << FRAC_BITS);
   localparam word_type FIX_HALF = word_type'(64'd1 << (FRAC_BITS - 1));
   localparam logic signed [63:0] SAT_HI = 64'(WORD_MAX);
   localparam logic signed [63:0] SAT_LO = 64'(WORD_MIN);

   // item opcodes
   localparam logic [1:0] OP_LOAD_MV  = 2'd0;
   localparam logic [1:0] OP_LOAD_PJ  = 2'd1;
   localparam logic [1:0] OP_PROJECT  = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_VP_X      = 2'd0;
   localparam logic [1:0] CSR_VP_Y      = 2'd1;
   localparam logic [1:0] CSR_VP_WIDTH  = 2'd2;
   localparam logic [1:0] CSR_VP_HEIGHT = 2'd3;

   typedef struct packed {
      logic [1:0]              opcode;
      logic [3:0]              entry_index;
      logic signed [WORD_WIDTH-1:0] entry_value;
      logic signed [WORD_WIDTH-1:0] obj_x;
      logic signed [WORD_WIDTH-1:0] obj_y;
      logic signed [WORD_WIDTH-1:0] obj_z;
   } req_type;

   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] win_x;
      logic signed [WORD_WIDTH-1:0] win_y;
      logic signed [WORD_WIDTH-1:0] win_z;
      logic                    valid_res;
   } rsp_type;

   // clamp to the signed word range
   function automatic word_type sat64(input logic signed [63:0] v);
      word_type r;
      if (v > SAT_HI) begin
         r = WORD_MAX;
      end else if (v < SAT_LO) begin
         r = WORD_MIN;
      end else begin
         r = v[WORD_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

FILE: design/vpw_dot_lane.sv
// ---------------------------------------------------------------------------
// vpw_dot_lane
// One matrix row times a vector: four registered products, then a
// floored sum that saturates to the word range and is registered as well.
// ---------------------------------------------------------------------------
module vpw_dot_lane (
   input  logic               clock,
   input  logic               en,
   input  vpw_pkg::vec4_type  vec_in,
   input  vpw_pkg::vec4_type  row_in,
   output vpw_pkg::word_type  sum_out
);

   logic signed [vpw_pkg::PROD_WIDTH-1:0] prod_ff [4];
   logic signed [vpw_pkg::PROD_WIDTH-1:0] prod_in [4];
   vpw_pkg::word_type                     sum_ff;
   vpw_pkg::word_type                     sum_in;

   // products
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         prod_in[i] = vpw_pkg::PROD_WIDTH'(signed'(vec_in[i]))
                    * vpw_pkg::PROD_WIDTH'(signed'(row_in[i]));
      end
   end

   // floor each product and add
   always_comb begin
      logic signed [vpw_pkg::ACC_WIDTH-1:0] acc;
      acc = '0;
      for (int i = 0; i < 4; i++) begin
         acc = acc + vpw_pkg::ACC_WIDTH'(prod_ff[i] >>> vpw_pkg::FRAC_BITS);
      end
      sum_in = vpw_pkg::sat64(64'(acc));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
      end
   end

   assign sum_out = sum_ff;

endmodule

FILE: design/vpw_div_lane.sv
// ---------------------------------------------------------------------------
// vpw_div_lane
// Pipelined restoring divide of a clip coordinate by clip w, one quotient
// bit per stage, then saturation and the map from [-1,1] to [0,1].
// ---------------------------------------------------------------------------
module vpw_div_lane (
   input  logic               clock,
   input  logic               en,
   input  vpw_pkg::word_type  num_in,
   input  vpw_pkg::word_type  den_in,
   output vpw_pkg::word_type  unit_out
);

   localparam int NS = vpw_pkg::DIV_STAGES;
   localparam int WW = vpw_pkg::WORD_WIDTH;
   localparam logic [NS-1:0] Q_POS_MAX = NS'(vpw_pkg::WORD_MAX);
   localparam logic [NS-1:0] Q_NEG_MAX = Q_POS_MAX + NS'(1);

   logic [WW-1:0] rem_ff [NS+1];
   logic [WW-1:0] rem_in [NS+1];
   logic [NS-1:0] dq_ff  [NS+1];
   logic [NS-1:0] dq_in  [NS+1];
   logic [WW-1:0] dsr_ff [NS+1];
   logic [WW-1:0] dsr_in [NS+1];
   logic          neg_ff [NS+1];
   logic          neg_in [NS+1];
   vpw_pkg::word_type unit_ff;
   vpw_pkg::word_type unit_in;

   function automatic logic [WW-1:0] den_in_mag(input vpw_pkg::word_type d);
      return d[WW-1] ? WW'(-d) : WW'(d);
   endfunction

   // magnitudes and sign, then one quotient bit per stage
   always_comb begin
      logic [WW:0] trial;
      logic [WW:0] diff;
      logic [WW-1:0] nmag;
      nmag      = num_in[WW-1] ? WW'(-num_in) : WW'(num_in);
      rem_in[0] = '0;
      dq_in[0]  = {nmag, {vpw_pkg::FRAC_BITS{1'b0}}};
      dsr_in[0] = den_in_mag(den_in);
      neg_in[0] = num_in[WW-1] ^ den_in[WW-1];
      for (int k = 0; k < NS; k++) begin
         trial = {rem_ff[k], dq_ff[k][NS-1]};
         diff  = trial - {1'b0, dsr_ff[k]};
         if (trial >= {1'b0, dsr_ff[k]}) begin
            rem_in[k+1] = diff[WW-1:0];
            dq_in[k+1]  = {dq_ff[k][NS-2:0], 1'b1};
         end else begin
            rem_in[k+1] = trial[WW-1:0];
            dq_in[k+1]  = {dq_ff[k][NS-2:0], 1'b0};
         end
         dsr_in[k+1] = dsr_ff[k];
         neg_in[k+1] = neg_ff[k];
      end
   end

   // saturate the signed quotient and map to the unit range
   always_comb begin
      vpw_pkg::word_type qs;
      logic [NS-1:0]     q;
      q = dq_ff[NS];
      if (!neg_ff[NS]) begin
         qs = (q > Q_POS_MAX) ? vpw_pkg::WORD_MAX : WW'(q);
      end else begin
         qs = (q > Q_NEG_MAX) ? vpw_pkg::WORD_MIN : WW'(-q);
      end
      unit_in = (qs >>> 1) + vpw_pkg::FIX_HALF;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         dq_ff   <= dq_in;
         dsr_ff  <= dsr_in;
         neg_ff  <= neg_in;
         unit_ff <= unit_in;
      end
   end

   assign unit_out = unit_ff;

endmodule

FILE: design/vertex_project_to_window.sv
// ---------------------------------------------------------------------------
// vertex_project_to_window
// Projects object-space vertices through the model-view and projection
// matrices to viewport window coordinates, signed Q16.16.
// ---------------------------------------------------------------------------
// Usage:
//   req channel carries one item per handshake (valid high, stall low).
//   Load items write one element of the model-view or projection matrix
//   and give no result; project items give exactly one rsp item.
//   A project item passes the two dot-product layers, the 48-stage quotient
//   pipeline of the three divide lanes, the viewport scale register and the
//   output register before it shows on rsp; one item may be accepted every
//   cycle while req_stall is low.
//   Loads take effect in item order: a project item always sees exactly
//   the loads accepted before it.
//   rsp_data sits in an output register; while rsp_stall holds a waiting
//   item, the whole pipeline freezes and req_stall is raised.
//   The csr port writes the viewport registers with no wait; write them
//   only while no item is in flight.
//   Synchronous reset empties the pipeline, loads identity matrices and
//   sets the viewport to origin 0,0 and size 640x480.
// ---------------------------------------------------------------------------
module vertex_project_to_window (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  vpw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output vpw_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata
);

   localparam int CLIP_I = 3;
   localparam int M1_I   = CLIP_I + vpw_pkg::DIV_LAT + 1;
   localparam int STAGES = M1_I + 1;

   logic en;
   logic accept;

   vpw_pkg::word_type mv_ff [16];
   vpw_pkg::word_type pj_ff [16];
   logic signed [15:0] vp_x_ff;
   logic signed [15:0] vp_y_ff;
   logic [15:0]        vp_w_ff;
   logic [15:0]        vp_h_ff;

   // projection-load sideband through the two model-view stages
   logic              ld_ff  [2];
   logic [3:0]        idx_ff [2];
   vpw_pkg::word_type val_ff [2];
   logic              vld_ff [STAGES];
   logic              vld_in [STAGES];
   logic              wz_ff  [STAGES];
   logic              wz_in  [STAGES];

   vpw_pkg::vec4_type obj_vec;
   vpw_pkg::vec4_type eye_vec;
   vpw_pkg::vec4_type mv_row [4];
   vpw_pkg::vec4_type pj_row [4];
   vpw_pkg::word_type eye [4];
   vpw_pkg::word_type clip [4];
   vpw_pkg::word_type unit [3];

   logic signed [vpw_pkg::MUL_WIDTH-1:0] px_ff, py_ff, px_in, py_in;
   vpw_pkg::word_type mz_ff;
   logic              rsp_valid_ff;
   vpw_pkg::rsp_type  rsp_data_ff;
   vpw_pkg::rsp_type  rsp_data_in;

   // pipeline advances unless a finished item is held
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;
   assign accept    = req_valid && en;

   // lane inputs
   always_comb begin
      obj_vec = {vpw_pkg::FIX_ONE, req_data.obj_z, req_data.obj_y, req_data.obj_x};
      eye_vec = {eye[3], eye[2], eye[1], eye[0]};
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            mv_row[r][c] = mv_ff[c*4 + r];
            pj_row[r][c] = pj_ff[c*4 + r];
         end
      end
   end

   // row lanes for both matrices
   for (genvar r = 0; r < 4; r++) begin : g_row
      vpw_dot_lane u_mv (
         .clock   (clock),
         .en      (en),
         .vec_in  (obj_vec),
         .row_in  (mv_row[r]),
         .sum_out (eye[r])
      );
      vpw_dot_lane u_pj (
         .clock   (clock),
         .en      (en),
         .vec_in  (eye_vec),
         .row_in  (pj_row[r]),
         .sum_out (clip[r])
      );
   end

   // divide lanes for x, y, z
   for (genvar a = 0; a < 3; a++) begin : g_div
      vpw_div_lane u_div (
         .clock    (clock),
         .en       (en),
         .num_in   (clip[a]),
         .den_in   (clip[3]),
         .unit_out (unit[a])
      );
   end

   // project valid and zero-w flags travel beside the lanes
   always_comb begin
      vld_in[0] = accept && (req_data.opcode == vpw_pkg::OP_PROJECT);
      wz_in[0]  = 1'b0;
      for (int i = 1; i < STAGES; i++) begin
         vld_in[i] = vld_ff[i-1];
         wz_in[i]  = (i == CLIP_I + 1) ? (clip[3] == '0) : wz_ff[i-1];
      end
   end

   // viewport scale
   always_comb begin
      px_in = vpw_pkg::MUL_WIDTH'(unit[0])
            * vpw_pkg::MUL_WIDTH'(signed'({1'b0, vp_w_ff}));
      py_in = vpw_pkg::MUL_WIDTH'(unit[1])
            * vpw_pkg::MUL_WIDTH'(signed'({1'b0, vp_h_ff}));
   end

   // offset, saturate and zero on a degenerate w
   always_comb begin
      rsp_data_in = '0;
      if (!wz_ff[M1_I]) begin
         rsp_data_in.win_x = vpw_pkg::sat64(64'(px_ff)
                           + (64'(vp_x_ff) <<< vpw_pkg::FRAC_BITS));
         rsp_data_in.win_y = vpw_pkg::sat64(64'(py_ff)
                           + (64'(vp_y_ff) <<< vpw_pkg::FRAC_BITS));
         rsp_data_in.win_z = mz_ff;
         rsp_data_in.valid_res = 1'b1;
      end
   end

   // control, matrices and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            mv_ff[i] <= (i % 5 == 0) ? vpw_pkg::FIX_ONE : '0;
            pj_ff[i] <= (i % 5 == 0) ? vpw_pkg::FIX_ONE : '0;
         end
         for (int i = 0; i < STAGES; i++) begin
            vld_ff[i] <= 1'b0;
         end
         ld_ff[0]     <= 1'b0;
         ld_ff[1]     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vp_x_ff      <= '0;
         vp_y_ff      <= '0;
         vp_w_ff      <= 16'd640;
         vp_h_ff      <= 16'd480;
      end else begin
         if (accept && req_data.opcode == vpw_pkg::OP_LOAD_MV) begin
            mv_ff[req_data.entry_index] <= req_data.entry_value;
         end
         if (en) begin
            ld_ff[0]     <= accept && (req_data.opcode == vpw_pkg::OP_LOAD_PJ);
            ld_ff[1]     <= ld_ff[0];
            vld_ff       <= vld_in;
            rsp_valid_ff <= vld_ff[STAGES-1];
            // projection loads land where the projection lanes read
            if (ld_ff[1]) begin
               pj_ff[idx_ff[1]] <= val_ff[1];
            end
         end
         if (csr_write_en) begin
            unique case (csr_index)
               vpw_pkg::CSR_VP_X:      vp_x_ff <= signed'(csr_wdata);
               vpw_pkg::CSR_VP_Y:      vp_y_ff <= signed'(csr_wdata);
               vpw_pkg::CSR_VP_WIDTH:  vp_w_ff <= csr_wdata;
               vpw_pkg::CSR_VP_HEIGHT: vp_h_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (en) begin
         idx_ff[0]   <= req_data.entry_index;
         val_ff[0]   <= req_data.entry_value;
         idx_ff[1]   <= idx_ff[0];
         val_ff[1]   <= val_ff[0];
         wz_ff       <= wz_in;
         px_ff       <= px_in;
         py_ff       <= py_in;
         mz_ff       <= unit[2];
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: design/vpw_checker.sv
// ---------------------------------------------------------------------------
// vpw_checker
// Port-level checks for the vertex projection block, bound to the top.
// ---------------------------------------------------------------------------
module vpw_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input vpw_pkg::rsp_type rsp_data
);

   // a held item stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item changed while stalled");

   // degenerate w gives an all-zero item
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.valid_res |->
         rsp_data.win_x == '0 && rsp_data.win_y == '0 && rsp_data.win_z == '0)
      else $error("failed projection carries nonzero coordinates");

   // input only backs up behind a held result
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled with no held result");

   // reset empties the output
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind vertex_project_to_window vpw_checker u_vpw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

FILE: sim/tb_vertex_project_to_window.sv
// ---------------------------------------------------------------------------
// tb_vertex_project_to_window
// Self-checking bench for the vertex projection block: matrix loads, unused
// opcodes and project items go in through the req channel with random gaps,
// results are checked against an in-bench fixed-point projection model, and
// the viewport registers are rewritten between phases while the block is idle.
// ---------------------------------------------------------------------------
module tb_vertex_project_to_window;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 80;
   localparam longint CYCLE_LIMIT = 1200000;
   // opcode with no meaning, ignored by the block
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   vpw_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   vpw_pkg::rsp_type rsp_data;
   logic    csr_write_en = 1'b0;
   logic [1:0]  csr_index = vpw_pkg::CSR_VP_X;
   logic [15:0] csr_wdata = '0;

   // model state
   longint mv_mat [16];
   longint pj_mat [16];
   longint vp_x, vp_y, vp_w, vp_h;

   vpw_pkg::req_type pending_items [$];
   vpw_pkg::rsp_type expected_windows [$];
   int  mismatches = 0;
   longint cycles = 0;
   int  send_gap = 0;
   int  recv_gap = 0;

   vertex_project_to_window DUT (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint clamp_word(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // arithmetic shift is floor division by a power of two
   function automatic longint floor_div(longint v, int s);
      return v >>> s;
   endfunction

   function automatic void transform(input longint m [16], input longint vin [4],
                                     output longint vout [4]);
      longint acc;
      for (int r = 0; r < 4; r++) begin
         acc = 0;
         for (int c = 0; c < 4; c++)
            acc += floor_div(vin[c] * m[c*4 + r], vpw_pkg::FRAC_BITS);
         vout[r] = clamp_word(acc);
      end
   endfunction

   function automatic longint unit_map(longint n, longint w);
      longint q;
      q = clamp_word((n * (64'sd1 <<< vpw_pkg::FRAC_BITS)) / w);
      return clamp_word(floor_div(q, 1) + (64'sd1 <<< (vpw_pkg::FRAC_BITS - 1)));
   endfunction

   function automatic void reset_model();
      for (int i = 0; i < 16; i++) begin
         mv_mat[i] = (i % 5 == 0) ? (64'sd1 <<< vpw_pkg::FRAC_BITS) : 0;
         pj_mat[i] = mv_mat[i];
      end
      vp_x = 0; vp_y = 0; vp_w = 640; vp_h = 480;
   endfunction

   // update state for one accepted item, queue its window result if any
   function automatic void predict_item(vpw_pkg::req_type it);
      longint obj [4], eye [4], clip [4];
      vpw_pkg::rsp_type r;
      if (it.opcode == vpw_pkg::OP_LOAD_MV) begin
         mv_mat[it.entry_index] = longint'(it.entry_value);
      end else if (it.opcode == vpw_pkg::OP_LOAD_PJ) begin
         pj_mat[it.entry_index] = longint'(it.entry_value);
      end else if (it.opcode == vpw_pkg::OP_PROJECT) begin
         obj[0] = longint'(it.obj_x);
         obj[1] = longint'(it.obj_y);
         obj[2] = longint'(it.obj_z);
         obj[3] = 64'sd1 <<< vpw_pkg::FRAC_BITS;
         transform(mv_mat, obj, eye);
         transform(pj_mat, eye, clip);
         r = '0;
         if (clip[3] != 0) begin
            r.win_x = 32'(clamp_word(unit_map(clip[0], clip[3]) * vp_w + vp_x * 65536));
            r.win_y = 32'(clamp_word(unit_map(clip[1], clip[3]) * vp_h + vp_y * 65536));
            r.win_z = 32'(unit_map(clip[2], clip[3]));
            r.valid_res = 1'b1;
         end
         expected_windows.push_back(r);
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_item(req_data);
            void'(pending_items.pop_front());
            send_gap = $urandom_range(0, 17);
            if ($urandom_range(0, 3) == 0) send_gap = 0;
            if (send_gap == 0 && pending_items.size() > 0) begin
               req_data <= pending_items[0];
            end else begin
               req_valid <= 1'b0;
            end
         end else if (!req_valid && pending_items.size() > 0) begin
            if (send_gap > 0) send_gap--;
            else begin
               req_valid <= 1'b1;
               req_data  <= pending_items[0];
            end
         end
      end
   end

   // monitor and stall generation
   always @(posedge clock) begin
      cycles++;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_windows.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", rsp_data);
            end else begin
               if (rsp_data !== expected_windows[0]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected x %h y %h z %h v %b, got x %h y %h z %h v %b",
                        expected_windows[0].win_x, expected_windows[0].win_y,
                        expected_windows[0].win_z, expected_windows[0].valid_res,
                        rsp_data.win_x, rsp_data.win_y, rsp_data.win_z, rsp_data.valid_res);
               end
               void'(expected_windows.pop_front());
            end
            recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            rsp_stall <= (recv_gap > 0);
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= (recv_gap > 0);
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("vertex_project_to_window test failed");
         $finish;
      end
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'($urandom_range(0, 65536*4)) - 32'h20000;
         default: return $urandom();
      endcase
   endfunction

   function automatic void add_load(logic [1:0] op, int idx, logic [31:0] v);
      vpw_pkg::req_type it;
      it = '0;
      it.opcode = op; it.entry_index = idx[3:0]; it.entry_value = v;
      it.obj_x = $urandom(); it.obj_y = $urandom(); it.obj_z = $urandom();
      pending_items.push_back(it);
   endfunction

   function automatic void add_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      vpw_pkg::req_type it;
      it.opcode = vpw_pkg::OP_PROJECT;
      it.entry_index = 4'($urandom());
      it.entry_value = $urandom();
      it.obj_x = x; it.obj_y = y; it.obj_z = z;
      pending_items.push_back(it);
   endfunction

   // a modest value in Q16.16 around +-4
   function automatic logic [31:0] mild();
      return 32'($urandom_range(0, 65536*8)) - 32'h40000;
   endfunction

   // write one register, block idle
   task automatic write_csr(logic [1:0] idx, logic [15:0] v);
      @(posedge clock);
      csr_write_en <= 1'b1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == vpw_pkg::CSR_VP_X) vp_x = longint'(signed'(v));
      else if (idx == vpw_pkg::CSR_VP_Y) vp_y = longint'(signed'(v));
      else if (idx == vpw_pkg::CSR_VP_WIDTH) vp_w = longint'(v);
      else vp_h = longint'(v);
   endtask

   task automatic wait_idle();
      while (pending_items.size() > 0 || req_valid || expected_windows.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [15:0] vp_sets [5][4];
      reset_model();
      vp_sets = '{'{16'h0, 16'h0, 16'd640, 16'd480},
                  '{16'h7fff, 16'h8000, 16'hffff, 16'hffff},
                  '{16'h8000, 16'h7fff, 16'h0, 16'h1},
                  '{16'd100, 16'hff00, 16'd1920, 16'd1080},
                  '{16'h0, 16'h0, 16'd640, 16'd480}};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: identity, extremes, zero w, unused opcode
      add_vertex(32'h0, 32'h0, 32'h0);
      add_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff);
      add_vertex(32'h80000000, 32'h7fffffff, 32'h80000000);
      add_vertex(32'h10000, 32'hffff0000, 32'h8000);
      begin
         vpw_pkg::req_type it;
         it = '1; it.opcode = OP_UNUSED;
         pending_items.push_back(it);
      end
      add_load(vpw_pkg::OP_LOAD_PJ, 15, 32'h0);
      add_vertex(32'h10000, 32'h20000, 32'h30000);
      add_load(vpw_pkg::OP_LOAD_PJ, 11, 32'hffff0000);
      add_load(vpw_pkg::OP_LOAD_PJ, 14, 32'h10000);
      add_vertex(32'h10000, 32'h20000, 32'h50000);
      add_vertex(32'h0, 32'h0, 32'h0);
      add_load(vpw_pkg::OP_LOAD_MV, 0, 32'h7fffffff);
      add_load(vpw_pkg::OP_LOAD_MV, 5, 32'h80000000);
      add_vertex(32'h7fffffff, 32'h7fffffff, 32'h10000);
      add_load(vpw_pkg::OP_LOAD_PJ, 15, 32'h1);
      add_vertex(32'h10000, 32'h10000, 32'h10000);
      wait_idle();

      // random phases across viewport settings
      for (int ph = 0; ph < 5; ph++) begin
         for (int k = 0; k < 4; k++) write_csr(k[1:0], vp_sets[ph][k]);
         for (int n = 0; n < 330; n++) begin
            int sel;
            sel = $urandom_range(0, 9);
            if (sel < 2) add_load(2'($urandom_range(0, 1)), $urandom_range(0, 15), mild());
            else if (sel == 2) add_load(2'($urandom_range(0, 1)), $urandom_range(0, 15),
                                        rand_word());
            else if (sel == 3) add_load(OP_UNUSED, $urandom_range(0, 15), rand_word());
            else if (sel < 8) add_vertex(mild(), mild(), mild());
            else add_vertex(rand_word(), rand_word(), rand_word());
         end
         wait_idle();
      end

      if (mismatches == 0) begin
         $display("vertex_project_to_window test passed");
      end else begin
         $display("vertex_project_to_window test failed");
      end
      $finish;
   end
endmodule

FILE: sim.f
design/vpw_pkg.sv
design/vpw_dot_lane.sv
design/vpw_div_lane.sv
design/vertex_project_to_window.sv
design/vpw_checker.sv
sim/tb_vertex_project_to_window.sv
